FILE: sv/pedec_pkg.sv
// Shared widths, register codes, reset values and item types of the peak envelope decimator.
`default_nettype none
package pedec_pkg;

	localparam int TOTAL_W = 24;
	localparam int COLS_W = 9;
	localparam int HALF_W = 8;
	localparam int SAMPLE_W = 16;
	localparam int IDX_W = 8;
	localparam int POSMAG_W = 15;
	localparam int NEGMAG_W = 16;
	localparam int DIV_W = TOTAL_W + COLS_W;
	localparam int SCALE_SHIFT = 15;

	localparam int RESULT_LIMIT = 64;
	localparam int CNT_W = $clog2(RESULT_LIMIT);
	localparam int QUEUE_DEPTH = 4;

	localparam int DEF_MAX_COLUMNS = 256;
	localparam int DEF_SAMPLE_INDEX_BITS = 24;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SAMPLES = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 8'd2;

	localparam logic [TOTAL_W-1:0] RST_TOTAL_SAMPLES = 24'd4;
	localparam logic [COLS_W-1:0] RST_COLUMN_COUNT = 9'd234;
	localparam logic [HALF_W-1:0] RST_HALF_HEIGHT = 8'd28;

	typedef struct packed {
		logic [POSMAG_W-1:0] pos_mag;
		logic [NEGMAG_W-1:0] neg_mag;
	} samp_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [COLS_W-1:0] cols;
		logic update;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] column;
		logic [POSMAG_W-1:0] peak_max;
		logic [NEGMAG_W-1:0] peak_min;
		logic last;
	} res_t;

endpackage
`default_nettype wire

FILE: sv/peak_envelope_decimator_top.sv
// Top level of the peak envelope decimator: configuration registers, input queue, column engine.
// Samples of one buffer enter on the sample channel and each display column, once its last
// sample is in, leaves as one item with its index and its peak rise and fall scaled to pixels.
// The column engine closes one column per cycle while the result output is not stalled, and
// after each closed column it rechecks the next boundary for the same sample, up to the
// sixty-fourth column or the end of the buffer, before it takes the next sample.
// After reset and after every configuration write the engine sets up the column boundaries
// in its serial divider; samples queue in the four-entry input buffer meanwhile.
`default_nettype none
module peak_envelope_decimator_top #(
	parameter int MAX_COLUMNS = pedec_pkg::DEF_MAX_COLUMNS,
	parameter int SAMPLE_INDEX_BITS = pedec_pkg::DEF_SAMPLE_INDEX_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [pedec_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pedec_pkg::TOTAL_W-1:0] cfg_wdata,
	input  wire logic sample_valid,
	output logic sample_ready,
	input  wire logic signed [pedec_pkg::SAMPLE_W-1:0] sample,
	output logic result_valid,
	input  wire logic result_ready,
	output logic [pedec_pkg::IDX_W-1:0] column_index,
	output logic [pedec_pkg::IDX_W-1:0] rise,
	output logic [pedec_pkg::IDX_W-1:0] fall,
	output logic last_column
);
	import pedec_pkg::*;

	localparam int CLAMP_W = COLS_W + 2;

	logic [TOTAL_W-1:0] total_q;
	logic [COLS_W-1:0] count_q;
	logic [HALF_W-1:0] half_q;
	logic [COLS_W-1:0] cols;
	cfg_t cfg;
	logic item_valid;
	samp_t item;
	logic pop;
	res_t result;
	logic [POSMAG_W+HALF_W-1:0] rise_prod;
	logic [NEGMAG_W+HALF_W-1:0] fall_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= RST_TOTAL_SAMPLES;
			count_q <= RST_COLUMN_COUNT;
			half_q <= RST_HALF_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL_SAMPLES: total_q <= cfg_wdata;
				CFG_COLUMN_COUNT: count_q <= cfg_wdata[COLS_W-1:0];
				CFG_HALF_HEIGHT: half_q <= cfg_wdata[HALF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		priority if (count_q == '0) cols = COLS_W'(1);
		else if (CLAMP_W'(count_q) > CLAMP_W'(MAX_COLUMNS)) cols = COLS_W'(MAX_COLUMNS);
		else cols = count_q;
		cfg.total = total_q;
		cfg.cols = cols;
		cfg.update = cfg_we;
	end

	pedec_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.pop         (pop),
		.item_valid  (item_valid),
		.item        (item)
	);

	pedec_back #(
		.MAX_COLUMNS      (MAX_COLUMNS),
		.SAMPLE_INDEX_BITS(SAMPLE_INDEX_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item_valid  (item_valid),
		.item_in     (item),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	assign rise_prod = result.peak_max * half_q;
	assign fall_prod = result.peak_min * half_q;
	assign column_index = result.column;
	assign rise = rise_prod[SCALE_SHIFT +: IDX_W];
	assign fall = fall_prod[SCALE_SHIFT +: IDX_W];
	assign last_column = result.last;

endmodule
`default_nettype wire

FILE: sv/pedec_div.sv
// Restoring divider, one quotient bit per cycle, for column boundary setup.
`default_nettype none
module pedec_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [pedec_pkg::DIV_W-1:0] dividend,
	input  wire logic [pedec_pkg::COLS_W-1:0] divisor,
	output logic done,
	output logic [pedec_pkg::DIV_W-1:0] quotient,
	output logic [pedec_pkg::COLS_W-1:0] remainder
);
	import pedec_pkg::*;

	localparam int STEP_W = $clog2(DIV_W);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0] quo_q;
	logic [COLS_W-1:0] rem_q;
	logic [COLS_W-1:0] divisor_q;
	logic [COLS_W:0] trial;
	logic fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? COLS_W'(trial - {1'b0, divisor_q}) : trial[COLS_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < divisor_q)
		else $error("Divider remainder is not below the divisor.");

endmodule
`default_nettype wire

FILE: sv/pedec_front.sv
// Input stage: takes samples, splits them into positive and negative magnitude, and queues them.
`default_nettype none
module pedec_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic sample_valid,
	output logic sample_ready,
	input  wire logic signed [pedec_pkg::SAMPLE_W-1:0] sample,
	input  wire logic pop,
	output logic item_valid,
	output pedec_pkg::samp_t item
);
	import pedec_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	samp_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	samp_t classified;
	logic push;
	logic take;

	always_comb begin
		classified.pos_mag = (!sample[SAMPLE_W-1] && sample != '0) ? sample[POSMAG_W-1:0] : '0;
		classified.neg_mag = sample[SAMPLE_W-1] ? NEGMAG_W'(~sample + 1'b1) : '0;
	end

	assign sample_ready = fill_q != FILL_W'(QUEUE_DEPTH);
	assign push = sample_valid && sample_ready;
	assign item_valid = fill_q != '0;
	assign take = pop && item_valid;
	assign item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (take) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !take) fill_q <= fill_q + 1'b1;
			else if (take && !push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= classified;
	end

endmodule
`default_nettype wire

FILE: sv/pedec_back.sv
// Column engine: tracks column boundaries, folds samples into peaks and emits closed columns.
`default_nettype none
module pedec_back #(
	parameter int MAX_COLUMNS = pedec_pkg::DEF_MAX_COLUMNS,
	parameter int SAMPLE_INDEX_BITS = pedec_pkg::DEF_SAMPLE_INDEX_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pedec_pkg::cfg_t cfg,
	input  wire logic item_valid,
	input  wire pedec_pkg::samp_t item_in,
	output logic pop,
	output logic result_valid,
	input  wire logic result_ready,
	output pedec_pkg::res_t result
);
	import pedec_pkg::*;

	localparam int COL_W = ($clog2(MAX_COLUMNS) > COLS_W) ? COLS_W : $clog2(MAX_COLUMNS);
	localparam int POS_W = SAMPLE_INDEX_BITS;
	localparam int CW = ((POS_W > TOTAL_W) ? POS_W : TOTAL_W) + 1;

	typedef enum logic [3:0] {
		S_CALC_Q = 4'b0001,
		S_CALC_S = 4'b0010,
		S_READY  = 4'b0100,
		S_BUSY   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic dirty_q, dirty_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [POSMAG_W-1:0] max_q, max_d;
	logic [NEGMAG_W-1:0] min_q, min_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic outv_q, outv_d;
	logic [CW-1:0] start_q, start_d;
	logic [CW-1:0] end_q, end_d;
	logic [COLS_W-1:0] rem_q, rem_d;
	logic [TOTAL_W-1:0] qn_q, qn_d;
	logic [COLS_W-1:0] rn_q, rn_d;
	samp_t hold_q, hold_d;
	res_t res_q, res_d;

	logic div_start;
	logic [DIV_W-1:0] div_dividend;
	logic div_done;
	logic [DIV_W-1:0] div_quot;
	logic [COLS_W-1:0] div_rem;
	logic [DIV_W-1:0] prod;

	samp_t item;
	logic work;
	logic restart;
	logic [POS_W-1:0] e_pos;
	logic [COL_W-1:0] e_col;
	logic [CW-1:0] e_start;
	logic [CW-1:0] e_end;
	logic [COLS_W-1:0] e_rem;
	logic [POSMAG_W-1:0] b_max, e_max;
	logic [NEGMAG_W-1:0] b_min, e_min;
	logic [CNT_W-1:0] e_cnt;
	logic [CW-1:0] p1;
	logic [CW-1:0] wend;
	logic close;
	logic can_emit;
	logic [COLS_W:0] col_inc;
	logic last;
	logic [COLS_W:0] n_sum;
	logic n_carry;
	logic [COLS_W-1:0] n_rem;
	logic [CW-1:0] n_end;
	logic n_absorb;
	logic [COLS_W:0] s_sum;
	logic s_carry;

	pedec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cfg.cols),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	assign prod = COLS_W'(col_q) * cfg.total;

	assign pop = (state_q == S_READY) && !dirty_q && item_valid;
	assign work = pop || (state_q == S_BUSY);
	assign restart = pop && (COLS_W'(col_q) >= cfg.cols);
	assign item = pop ? item_in : hold_q;

	always_comb begin
		e_pos = restart ? '0 : pos_q;
		e_col = restart ? '0 : col_q;
		e_start = restart ? '0 : start_q;
		e_end = restart ? CW'(qn_q) : end_q;
		e_rem = restart ? rn_q : rem_q;
		b_max = restart ? '0 : max_q;
		b_min = restart ? '0 : min_q;
		e_max = b_max;
		e_min = b_min;
		e_cnt = cnt_q;
		if (pop) begin
			e_cnt = '0;
			if (item.pos_mag > b_max) e_max = item.pos_mag;
			if (item.neg_mag > b_min) e_min = item.neg_mag;
		end
		p1 = CW'(e_pos) + CW'(1);
		wend = (e_end <= e_start) ? e_start + CW'(1) : e_end;
		close = wend <= p1;
		can_emit = !outv_q || result_ready;
		col_inc = (COLS_W+1)'(e_col) + (COLS_W+1)'(1);
		last = col_inc == {1'b0, cfg.cols};
		n_sum = {1'b0, e_rem} + {1'b0, rn_q};
		n_carry = n_sum >= {1'b0, cfg.cols};
		n_rem = n_carry ? COLS_W'(n_sum - {1'b0, cfg.cols}) : n_sum[COLS_W-1:0];
		n_end = e_end + CW'(qn_q) + CW'(n_carry);
		n_absorb = e_end <= CW'(e_pos);
		s_sum = {1'b0, div_rem} + {1'b0, rn_q};
		s_carry = s_sum >= {1'b0, cfg.cols};
	end

	always_comb begin
		state_d = state_q;
		dirty_d = dirty_q || cfg.update;
		pos_d = pos_q;
		col_d = col_q;
		max_d = max_q;
		min_d = min_q;
		cnt_d = cnt_q;
		start_d = start_q;
		end_d = end_q;
		rem_d = rem_q;
		qn_d = qn_q;
		rn_d = rn_q;
		hold_d = hold_q;
		res_d = res_q;
		outv_d = outv_q && !result_ready;
		div_start = 1'b0;
		div_dividend = DIV_W'(cfg.total);

		unique case (state_q)
			S_READY: begin
				if (dirty_q) begin
					div_start = 1'b1;
					dirty_d = cfg.update;
					state_d = S_CALC_Q;
				end
			end
			S_CALC_Q: begin
				if (div_done) begin
					qn_d = TOTAL_W'(div_quot);
					rn_d = div_rem;
					div_start = 1'b1;
					div_dividend = prod;
					state_d = S_CALC_S;
				end
			end
			S_CALC_S: begin
				if (div_done) begin
					start_d = CW'(div_quot);
					end_d = CW'(div_quot) + CW'(qn_q) + CW'(s_carry);
					rem_d = s_carry ? COLS_W'(s_sum - {1'b0, cfg.cols}) : s_sum[COLS_W-1:0];
					state_d = S_READY;
				end
			end
			S_BUSY: begin
			end
			default: begin
				state_d = S_READY;
			end
		endcase

		if (work) begin
			hold_d = item;
			if (!close) begin
				pos_d = POS_W'(p1);
				col_d = e_col;
				start_d = e_start;
				end_d = e_end;
				rem_d = e_rem;
				max_d = e_max;
				min_d = e_min;
				state_d = S_READY;
			end else if (!can_emit) begin
				pos_d = e_pos;
				col_d = e_col;
				start_d = e_start;
				end_d = e_end;
				rem_d = e_rem;
				max_d = e_max;
				min_d = e_min;
				cnt_d = e_cnt;
				state_d = S_BUSY;
			end else begin
				outv_d = 1'b1;
				res_d.column = IDX_W'(e_col);
				res_d.peak_max = e_max;
				res_d.peak_min = e_min;
				res_d.last = last;
				if (last) begin
					pos_d = '0;
					col_d = '0;
					start_d = '0;
					end_d = CW'(qn_q);
					rem_d = rn_q;
					max_d = '0;
					min_d = '0;
					state_d = S_READY;
				end else begin
					col_d = COL_W'(col_inc);
					start_d = e_end;
					end_d = n_end;
					rem_d = n_rem;
					max_d = n_absorb ? item.pos_mag : '0;
					min_d = n_absorb ? item.neg_mag : '0;
					if (e_cnt == CNT_W'(RESULT_LIMIT - 1)) begin
						pos_d = POS_W'(p1);
						state_d = S_READY;
					end else begin
						pos_d = e_pos;
						cnt_d = e_cnt + 1'b1;
						state_d = S_BUSY;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_READY;
			dirty_q <= 1'b1;
			pos_q <= '0;
			col_q <= '0;
			max_q <= '0;
			min_q <= '0;
			cnt_q <= '0;
			outv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dirty_q <= dirty_d;
			pos_q <= pos_d;
			col_q <= col_d;
			max_q <= max_d;
			min_q <= min_d;
			cnt_q <= cnt_d;
			outv_q <= outv_d;
		end
	end

	always_ff @(posedge clk) begin
		start_q <= start_d;
		end_q <= end_d;
		rem_q <= rem_d;
		qn_q <= qn_d;
		rn_q <= rn_d;
		hold_q <= hold_d;
		res_q <= res_d;
	end

	assign result_valid = outv_q;
	assign result = res_q;

	a_quotient_then_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC_Q) && div_done |=> state_q == S_CALC_S)
		else $error("Boundary setup skipped the column start division.");

	a_busy_column_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUSY) |-> COLS_W'(col_q) < cfg.cols)
		else $error("An item is in progress on a column past the last one.");

	a_remainder_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READY) && !dirty_q |-> rem_q < cfg.cols)
		else $error("Boundary remainder is not below the column count.");

	a_end_not_before_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUSY) |-> end_q >= start_q)
		else $error("Column end lies before its start.");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the peak envelope decimator: directed and random sample buffers.
`timescale 1ns / 100ps
module testbench;
	import pedec_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE_CYCLES = 150;
	localparam int REPORT_LIMIT = 10;
	localparam longint unsigned POS_MASK = (64'd1 << DEF_SAMPLE_INDEX_BITS) - 1;

	typedef struct packed {
		logic [IDX_W-1:0] column;
		logic [IDX_W-1:0] rise;
		logic [IDX_W-1:0] fall;
		logic last;
	} column_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TOTAL_SAMPLES;
	logic [TOTAL_W-1:0] cfg_wdata = '0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [IDX_W-1:0] column_index;
	logic [IDX_W-1:0] rise;
	logic [IDX_W-1:0] fall;
	logic last_column;

	int send_gap_pct = 0;
	int stall_pct = 0;
	int err_count = 0;
	int cycle_count = 0;
	int samples_sent = 0;
	int columns_seen = 0;
	int settings_used = 0;

	int unsigned reg_total = RST_TOTAL_SAMPLES;
	int unsigned reg_cols = RST_COLUMN_COUNT;
	int unsigned reg_half = RST_HALF_HEIGHT;

	int unsigned position = 0;
	int unsigned open_col = 0;
	int unsigned peak_max = 0;
	int unsigned peak_neg = 0;

	column_result_t pending_columns[$];

	peak_envelope_decimator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.column_index(column_index),
		.rise(rise),
		.fall(fall),
		.last_column(last_column)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d columns outstanding.", cycle_count,
				pending_columns.size());
			$display("[peak_envelope_decimator_top] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	always @(posedge clk) begin
		column_result_t exp_col;
		if (arst_n && result_valid && result_ready) begin
			columns_seen++;
			if (pending_columns.size() == 0) begin
				note_error($sformatf("Unexpected column %0d (rise %0d fall %0d last %0b).",
					column_index, rise, fall, last_column));
			end else begin
				exp_col = pending_columns.pop_front();
				if (column_index !== exp_col.column || rise !== exp_col.rise ||
					fall !== exp_col.fall || last_column !== exp_col.last) begin
					note_error($sformatf({"Column mismatch: expected col %0d rise %0d fall %0d ",
						"last %0b, got col %0d rise %0d fall %0d last %0b."},
						exp_col.column, exp_col.rise, exp_col.fall, exp_col.last,
						column_index, rise, fall, last_column));
				end
			end
		end
	end

	function automatic longint unsigned span_start(input int unsigned col,
		input int unsigned cols);
		return (longint'(col) * longint'(reg_total)) / cols;
	endfunction

	function automatic longint unsigned span_end(input int unsigned col,
		input int unsigned cols);
		longint unsigned raw;
		longint unsigned first;
		raw = (longint'(col + 1) * longint'(reg_total)) / cols;
		first = span_start(col, cols);
		return (raw <= first) ? first + 1 : raw;
	endfunction

	function automatic void take_peak(input int v);
		if (v > 0 && v > int'(peak_max))
			peak_max = v;
		if (v < 0 && -v > int'(peak_neg))
			peak_neg = -v;
	endfunction

	function automatic void restart_buffer();
		position = 0;
		open_col = 0;
		peak_max = 0;
		peak_neg = 0;
	endfunction

	function automatic void predict_column_peaks(input logic signed [SAMPLE_W-1:0] s);
		int unsigned cols;
		longint unsigned p;
		int produced;
		bit done;
		column_result_t r;
		cols = (reg_cols < 1) ? 1 : (reg_cols > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : reg_cols;
		if (open_col >= cols)
			restart_buffer();
		p = position;
		take_peak(int'(s));
		produced = 0;
		done = 1'b0;
		while (produced < RESULT_LIMIT) begin
			if (span_end(open_col, cols) > p + 1)
				break;
			r.column = open_col[IDX_W-1:0];
			r.rise = IDX_W'((peak_max * reg_half) >> SCALE_SHIFT);
			r.fall = IDX_W'((peak_neg * reg_half) >> SCALE_SHIFT);
			r.last = (open_col + 1 == cols);
			pending_columns.push_back(r);
			produced++;
			peak_max = 0;
			peak_neg = 0;
			open_col++;
			if (open_col >= cols) begin
				done = 1'b1;
				break;
			end
			if (span_start(open_col, cols) <= p)
				take_peak(int'(s));
		end
		if (done)
			restart_buffer();
		else
			position = int'((p + 1) & POS_MASK);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
		else if (pick <= 3)
			return SAMPLE_W'(int'($urandom_range(0, 600)) - 300);
		else
			return SAMPLE_W'($urandom_range(0, 65535));
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= v;
		predict_column_peaks(v);
		samples_sent++;
		do
			@(posedge clk);
		while (!sample_ready);
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		while (pending_columns.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned n, input int unsigned c, input int unsigned h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TOTAL_SAMPLES;
		cfg_wdata <= TOTAL_W'(n);
		@(posedge clk);
		cfg_index <= CFG_COLUMN_COUNT;
		cfg_wdata <= TOTAL_W'(c & 32'h1FF);
		@(posedge clk);
		cfg_index <= CFG_HALF_HEIGHT;
		cfg_wdata <= TOTAL_W'(h & 32'hFF);
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_total = n & 32'hFF_FFFF;
		reg_cols = c & 32'h1FF;
		reg_half = h & 32'hFF;
		settings_used++;
	endtask

	// The default registers spread four samples over 234 columns.
	task automatic test_reset_defaults();
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(-16'sd1);
		settle();
	endtask

	task automatic test_column_count_clamp();
		set_config(4, 0, 255);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		settle();
		set_config(6, 500, 1);
		send_sample(16'sd16384);
		send_sample(-16'sd16384);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		send_sample(16'sd5);
		settle();
	endtask

	task automatic test_overflow_catchup();
		set_config(2, 256, 200);
		send_sample(16'sd1000);
		send_sample(-16'sd2000);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		settle();
	endtask

	task automatic test_midbuffer_change();
		set_config(8, 4, 100);
		repeat (5) send_sample(random_sample());
		settle();
		set_config(8, 2, 100);
		repeat (3) send_sample(random_sample());
		settle();
		set_config(4, 2, 100);
		repeat (2) send_sample(random_sample());
		settle();
	endtask

	task automatic test_random_buffers(input int gap, input int stall, input int budget);
		int sent;
		int pick;
		int unsigned n_val;
		int unsigned c_val;
		int unsigned h_val;
		int len;
		send_gap_pct = gap;
		stall_pct = stall;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				n_val = $urandom_range(0, 3);
			else if (pick == 1)
				n_val = 24'hFF_FFFF;
			else if (pick < 7)
				n_val = $urandom_range(4, 12);
			else
				n_val = $urandom_range(4, 48);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				c_val = 1;
			else if (pick == 1)
				c_val = 256;
			else if (pick == 2)
				c_val = $urandom_range(257, 511);
			else if (pick == 3)
				c_val = 0;
			else
				c_val = $urandom_range(1, 256);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				h_val = 1;
			else if (pick == 1)
				h_val = 255;
			else
				h_val = $urandom_range(1, 255);
			settle();
			set_config(n_val, c_val, h_val);
			len = (n_val > 64) ? $urandom_range(1, 6) : (n_val < 4) ? 4 : n_val;
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(1, len);
			repeat (len) begin
				send_sample(random_sample());
				sent++;
			end
		end
		settle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 38;
		stall_pct = 59;
		test_reset_defaults();
		test_column_count_clamp();
		test_overflow_catchup();
		test_midbuffer_change();
		test_random_buffers(38, 59, 50);
		test_random_buffers(59, 38, 50);
		test_random_buffers(0, 0, 50);
		settle();
		$display("Sent %0d samples under %0d register settings; %0d columns came back.",
			samples_sent, settings_used, columns_seen);
		$display("Mismatches and unexpected columns: %0d.", err_count);
		if (err_count == 0)
			$display("[peak_envelope_decimator_top] OK");
		else
			$display("[peak_envelope_decimator_top] ERROR");
		$finish;
	end

endmodule
